### rtl/dptd_pkg.sv
// Shared constants and types of the Doppler peak target detector.
`timescale 1ns / 1ps

package dptd_pkg;

	localparam int FRAME_BINS  = 1024;
	localparam int MAX_TARGETS = 16;
	localparam int Q_DEPTH     = 4;

	localparam int BIN_W     = $clog2(FRAME_BINS);
	localparam int ACC_W     = $clog2(MAX_TARGETS + 1);
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_BINS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_BIN = 3'd4;

	localparam logic KIND_TARGET  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic DIR_APPROACHING = 1'b0;
	localparam logic DIR_RECEDING    = 1'b1;

	// One queue entry holds every result that one bin produces.
	typedef struct packed {
		logic        rec_v;
		logic        app_v;
		logic        sum_v;
		logic [9:0]  bin;
		logic [31:0] speed;
		logic [4:0]  rec_cnt;
		logic        rec_drop;
		logic [4:0]  app_cnt;
		logic        app_drop;
		logic [4:0]  sum_cnt;
		logic        sum_drop;
	} entry_t;

endpackage

### rtl/dptd_front.sv
// Front end: configuration registers, per-side peak search and result classification.
`timescale 1ns / 1ps

module dptd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dptd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     receding_magnitude,
	input  logic [31:0]                     approaching_magnitude,
	input  logic                            last_bin,
	output logic                            push,
	output dptd_pkg::entry_t                push_data,
	input  logic                            full
);
	import dptd_pkg::*;

	logic [31:0]      thr_q;
	logic [10:0]      low_q;
	logic [10:0]      high_q;
	logic [9:0]       skip_cfg_q;
	logic [31:0]      spb_q;

	logic [BIN_W-1:0] bin_cnt_q;
	logic [31:0]      prior_q  [2];
	logic [31:0]      cand_m_q [2];
	logic             cand_v_q [2];
	logic [31:0]      rmax_q   [2];
	logic [9:0]       skip_q   [2];
	logic [ACC_W-1:0] acc_q;
	logic             drop_q;

	logic [31:0]      x        [2];
	logic             hit      [2];
	logic [31:0]      prior_n  [2];
	logic [31:0]      cand_m_n [2];
	logic             cand_v_n [2];
	logic [31:0]      rmax_n   [2];
	logic [9:0]       skip_n   [2];

	logic                   accept;
	logic                   closing;
	logic                   in_band;
	logic [BIN_W-1:0]       bin_m1;
	logic [BIN_W+31:0]      product;
	logic [31:0]            speed;
	logic                   rep0;
	logic                   rep1;
	logic [ACC_W-1:0]       acc1;
	logic [ACC_W-1:0]       acc2;
	logic                   drop1;
	logic                   drop2;

	function automatic logic [4:0] to_count(input logic [ACC_W-1:0] v);
		logic [ACC_W+4:0] w;
		w = {5'b0, v};
		return w[4:0];
	endfunction

	function automatic logic [9:0] to_bin(input logic [BIN_W-1:0] v);
		logic [BIN_W+9:0] w;
		w = {10'b0, v};
		return w[9:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	assign x[0] = receding_magnitude;
	assign x[1] = approaching_magnitude;

	assign closing = last_bin || (bin_cnt_q == BIN_W'(FRAME_BINS - 1));
	assign in_band = ({11'b0, bin_cnt_q} >= {{BIN_W{1'b0}}, low_q}) &&
		({11'b0, bin_cnt_q} < {{BIN_W{1'b0}}, high_q});

	// A reported peak always lies one bin behind the current one.
	assign bin_m1  = bin_cnt_q - BIN_W'(1);
	assign product = {32'b0, bin_m1} * {{BIN_W{1'b0}}, spb_q};
	assign speed   = (product[BIN_W+31:32] != '0) ? 32'hFFFF_FFFF : product[31:0];

	always_comb begin
		logic [9:0]  skip_eff;
		logic [31:0] rmax_eff;
		for (int s = 0; s < 2; s++) begin
			hit[s]      = cand_v_q[s] && (x[s] < cand_m_q[s]);
			skip_eff    = hit[s] ? skip_cfg_q : skip_q[s];
			rmax_eff    = hit[s] ? 32'd0 : rmax_q[s];
			skip_n[s]   = skip_eff;
			rmax_n[s]   = rmax_eff;
			cand_v_n[s] = 1'b0;
			cand_m_n[s] = cand_m_q[s];
			prior_n[s]  = x[s];
			if (skip_eff != 10'd0) begin
				skip_n[s] = skip_eff - 10'd1;
			end else if (bin_cnt_q == '0) begin
				rmax_n[s] = x[s];
			end else if (in_band && (x[s] > rmax_eff) && (x[s] > thr_q)) begin
				rmax_n[s] = x[s];
				if ((prior_q[s] < x[s]) && !closing) begin
					cand_v_n[s] = 1'b1;
					cand_m_n[s] = x[s];
				end
			end
		end
	end

	assign rep0  = hit[0] && (acc_q < ACC_W'(MAX_TARGETS));
	assign acc1  = acc_q + ACC_W'(rep0);
	assign drop1 = drop_q || (hit[0] && !rep0);
	assign rep1  = hit[1] && (acc1 < ACC_W'(MAX_TARGETS));
	assign acc2  = acc1 + ACC_W'(rep1);
	assign drop2 = drop1 || (hit[1] && !rep1);

	assign push = accept && (rep0 || rep1 || closing);

	always_comb begin
		push_data.rec_v    = rep0;
		push_data.app_v    = rep1;
		push_data.sum_v    = closing;
		push_data.bin      = to_bin(bin_m1);
		push_data.speed    = speed;
		push_data.rec_cnt  = to_count(acc1);
		push_data.rec_drop = drop_q;
		push_data.app_cnt  = to_count(acc2);
		push_data.app_drop = drop1;
		push_data.sum_cnt  = to_count(acc2);
		push_data.sum_drop = drop2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= 32'd0;
			low_q      <= 11'd1;
			high_q     <= 11'd1024;
			skip_cfg_q <= 10'd0;
			spb_q      <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD:     thr_q      <= cfg_data;
				REG_LOW_BIN:       low_q      <= cfg_data[10:0];
				REG_HIGH_BIN:      high_q     <= cfg_data[10:0];
				REG_SKIP_BINS:     skip_cfg_q <= cfg_data[9:0];
				REG_SPEED_PER_BIN: spb_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q <= '0;
			acc_q     <= '0;
			drop_q    <= 1'b0;
			for (int s = 0; s < 2; s++) begin
				prior_q[s]  <= 32'd0;
				cand_m_q[s] <= 32'd0;
				cand_v_q[s] <= 1'b0;
				rmax_q[s]   <= 32'd0;
				skip_q[s]   <= 10'd0;
			end
		end else if (accept) begin
			if (closing) begin
				bin_cnt_q <= '0;
				acc_q     <= '0;
				drop_q    <= 1'b0;
				for (int s = 0; s < 2; s++) begin
					prior_q[s]  <= 32'd0;
					cand_m_q[s] <= 32'd0;
					cand_v_q[s] <= 1'b0;
					rmax_q[s]   <= 32'd0;
					skip_q[s]   <= 10'd0;
				end
			end else begin
				bin_cnt_q <= bin_cnt_q + BIN_W'(1);
				acc_q     <= acc2;
				drop_q    <= drop2;
				for (int s = 0; s < 2; s++) begin
					prior_q[s]  <= prior_n[s];
					cand_m_q[s] <= cand_m_n[s];
					cand_v_q[s] <= cand_v_n[s];
					rmax_q[s]   <= rmax_n[s];
					skip_q[s]   <= skip_n[s];
				end
			end
		end
	end

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= ACC_W'(MAX_TARGETS))
		else $error("Accepted target count exceeds the maximum.");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && closing |=> bin_cnt_q == '0 && acc_q == '0 && !drop_q)
		else $error("Frame state not cleared after the closing bin.");

	a_no_cand_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && closing |=> !cand_v_q[0] && !cand_v_q[1])
		else $error("Candidate survived the end of a frame.");

endmodule

### rtl/dptd_fifo.sv
// Short result queue between the front end and the back end.
`timescale 1ns / 1ps

module dptd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dptd_pkg::entry_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output dptd_pkg::entry_t  head
);
	import dptd_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	entry_t           mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("Push into a full queue.");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("Pop from an empty queue.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(Q_DEPTH))
		else $error("Queue occupancy out of range.");

endmodule

### rtl/dptd_back.sv
// Back end: splits each queue entry into result beats and holds the output register.
`timescale 1ns / 1ps

module dptd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  dptd_pkg::entry_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic              direction,
	output logic [9:0]        bin_index,
	output logic [31:0]       speed_kph,
	output logic [4:0]        target_count,
	output logic              overflow,
	output logic              last
);
	import dptd_pkg::*;

	logic        out_v_q;
	logic        kind_q;
	logic        dir_q;
	logic [9:0]  bin_q;
	logic [31:0] speed_q;
	logic [4:0]  cnt_q;
	logic        ovf_q;
	logic        last_q;
	logic        rec_done_q;
	logic        app_done_q;

	logic load;
	logic rec_p;
	logic app_p;
	logic sel_last;

	assign load  = !empty && (!out_v_q || !out_stall);
	assign rec_p = head.rec_v && !rec_done_q;
	assign app_p = head.app_v && !app_done_q;

	always_comb begin
		if (rec_p) begin
			sel_last = !app_p && !head.sum_v;
		end else if (app_p) begin
			sel_last = !head.sum_v;
		end else begin
			sel_last = 1'b1;
		end
	end

	assign pop = load && sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			rec_done_q <= 1'b0;
			app_done_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (pop) begin
				rec_done_q <= 1'b0;
				app_done_q <= 1'b0;
			end else if (load) begin
				if (rec_p) begin
					rec_done_q <= 1'b1;
				end else begin
					app_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= sel_last;
			if (rec_p) begin
				kind_q  <= KIND_TARGET;
				dir_q   <= DIR_RECEDING;
				bin_q   <= head.bin;
				speed_q <= head.speed;
				cnt_q   <= head.rec_cnt;
				ovf_q   <= head.rec_drop;
			end else if (app_p) begin
				kind_q  <= KIND_TARGET;
				dir_q   <= DIR_APPROACHING;
				bin_q   <= head.bin;
				speed_q <= head.speed;
				cnt_q   <= head.app_cnt;
				ovf_q   <= head.app_drop;
			end else begin
				kind_q  <= KIND_SUMMARY;
				dir_q   <= DIR_APPROACHING;
				bin_q   <= 10'd0;
				speed_q <= 32'd0;
				cnt_q   <= head.sum_cnt;
				ovf_q   <= head.sum_drop;
			end
		end
	end

	assign out_valid    = out_v_q;
	assign kind         = kind_q;
	assign direction    = dir_q;
	assign bin_index    = bin_q;
	assign speed_kph    = speed_q;
	assign target_count = cnt_q;
	assign overflow     = ovf_q;
	assign last         = last_q;

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && kind_q == KIND_SUMMARY |-> last_q && bin_q == 10'd0 && speed_q == 32'd0)
		else $error("Summary beat is malformed.");

	a_rec_done_head: assert property (@(posedge clk) disable iff (!arst_n)
		rec_done_q |-> !empty && head.rec_v)
		else $error("Receding report marked sent without a pending entry.");

	a_app_done_tail: assert property (@(posedge clk) disable iff (!arst_n)
		app_done_q |-> !empty && head.app_v && head.sum_v)
		else $error("Approaching report marked sent without a following summary.");

endmodule

### rtl/doppler_peak_target_detector_core.sv
// Top level of the Doppler peak target detector.
//
//   Channel  Handshake               Payload
//   input    in_valid / in_stall     receding_magnitude, approaching_magnitude, last_bin
//   output   out_valid / out_stall   kind, direction, bin_index, speed_kph, target_count,
//                                    overflow, last
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The front end takes one bin per cycle and writes a queue entry for every bin that
// yields results; the speed product is formed there in the same cycle.
// The back end sends one result beat per cycle unless stalled; an entry is held until
// all are sent; the four-entry queue absorbs bursts and the input stalls only when full.
// Reset is asynchronous and clears all control and search state; no clearing pass.
// An output stall holds the output register and backs up into the queue.
`timescale 1ns / 1ps

module doppler_peak_target_detector_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dptd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     receding_magnitude,
	input  logic [31:0]                     approaching_magnitude,
	input  logic                            last_bin,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            kind,
	output logic                            direction,
	output logic [9:0]                      bin_index,
	output logic [31:0]                     speed_kph,
	output logic [4:0]                      target_count,
	output logic                            overflow,
	output logic                            last
);
	import dptd_pkg::*;

	logic   push;
	entry_t push_data;
	logic   full;
	logic   pop;
	logic   empty;
	entry_t head;

	dptd_front u_front (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.receding_magnitude    (receding_magnitude),
		.approaching_magnitude (approaching_magnitude),
		.last_bin              (last_bin),
		.push                  (push),
		.push_data             (push_data),
		.full                  (full)
	);

	dptd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	dptd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.direction    (direction),
		.bin_index    (bin_index),
		.speed_kph    (speed_kph),
		.target_count (target_count),
		.overflow     (overflow),
		.last         (last)
	);

endmodule

### tb/doppler_peak_target_detector_core_tb.sv
// Self-checking testbench of the Doppler peak target detector core.
`timescale 1ns / 1ps

module doppler_peak_target_detector_core_tb;

	import dptd_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_ITEMS  = 60;
	localparam int REPORT_LIMIT  = 40;

	typedef struct packed {
		logic        kind;
		logic        direction;
		logic [9:0]  bin_index;
		logic [31:0] speed_kph;
		logic [4:0]  target_count;
		logic        overflow;
		logic        last;
	} det_result_t;

	typedef enum int {FR_SCALED, FR_ZIGZAG, FR_NOISE} frame_style_e;

	class target_scoreboard;
		bit [31:0]   thr_r;
		bit [10:0]   low_r;
		bit [10:0]   high_r;
		bit [9:0]    skip_r;
		bit [31:0]   speed_r;
		bit [9:0]    bin_cnt;
		bit [31:0]   prior[2];
		bit [31:0]   cand_mag[2];
		bit          cand_v[2];
		bit [31:0]   run_max[2];
		bit [9:0]    skip_left[2];
		bit [4:0]    accepted;
		bit          dropped;
		int          errors;
		det_result_t pending_reports[$];

		function new();
			thr_r   = 32'd0;
			low_r   = 11'd1;
			high_r  = 11'd1024;
			skip_r  = 10'd0;
			speed_r = 32'd65536;
			errors  = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			bin_cnt  = '0;
			accepted = '0;
			dropped  = 1'b0;
			for (int s = 0; s < 2; s++) begin
				prior[s]     = '0;
				cand_mag[s]  = '0;
				cand_v[s]    = 1'b0;
				run_max[s]   = '0;
				skip_left[s] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_THRESHOLD:     thr_r   = data;
				REG_LOW_BIN:       low_r   = data[10:0];
				REG_HIGH_BIN:      high_r  = data[10:0];
				REG_SKIP_BINS:     skip_r  = data[9:0];
				REG_SPEED_PER_BIN: speed_r = data;
				default: ;
			endcase
		endfunction

		function void push_result(logic k, logic dir, logic [9:0] bin, logic [31:0] spd);
			det_result_t r;
			r.kind         = k;
			r.direction    = dir;
			r.bin_index    = bin;
			r.speed_kph    = spd;
			r.target_count = accepted;
			r.overflow     = dropped;
			r.last         = 1'b0;
			pending_reports.push_back(r);
		endfunction

		function void side_step(int s, bit [31:0] x, bit [9:0] j, bit closing);
			bit [63:0] prod;
			bit [9:0]  peak;
			if (cand_v[s]) begin
				cand_v[s] = 1'b0;
				if (x < cand_mag[s]) begin
					peak         = j - 10'd1;
					run_max[s]   = '0;
					skip_left[s] = skip_r;
					if (accepted < MAX_TARGETS) begin
						prod = 64'(peak) * 64'(speed_r);
						accepted++;
						push_result(KIND_TARGET, (s == 0) ? DIR_RECEDING : DIR_APPROACHING, peak,
							(prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0]);
					end else begin
						dropped = 1'b1;
					end
				end
			end
			if (skip_left[s] > 0) begin
				skip_left[s]--;
			end else if (j == 0) begin
				run_max[s] = x;
			end else if (j >= low_r && j < high_r && x > run_max[s] && x > thr_r) begin
				run_max[s] = x;
				if (prior[s] < x && !closing) begin
					cand_v[s]   = 1'b1;
					cand_mag[s] = x;
				end
			end
			prior[s] = x;
		endfunction

		function void note_bin(logic [31:0] rec, logic [31:0] app, logic mark);
			bit [9:0] j;
			bit       closing;
			int       n_before;
			n_before = pending_reports.size();
			j        = bin_cnt;
			closing  = mark || (j == 10'(FRAME_BINS - 1));
			side_step(0, rec, j, closing);
			side_step(1, app, j, closing);
			if (closing) begin
				push_result(KIND_SUMMARY, DIR_APPROACHING, '0, '0);
				clear_frame();
			end else begin
				bin_cnt = j + 10'd1;
			end
			if (pending_reports.size() > n_before)
				pending_reports[pending_reports.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task check_result(det_result_t got);
			det_result_t want;
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d bin %0d",
					got.kind, got.bin_index));
				return;
			end
			want = pending_reports.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
			if (got.direction !== want.direction)
				report_mismatch($sformatf("direction got %0d want %0d",
					got.direction, want.direction));
			if (got.bin_index !== want.bin_index)
				report_mismatch($sformatf("bin_index got %0d want %0d",
					got.bin_index, want.bin_index));
			if (got.speed_kph !== want.speed_kph)
				report_mismatch($sformatf("speed_kph got %h want %h",
					got.speed_kph, want.speed_kph));
			if (got.target_count !== want.target_count)
				report_mismatch($sformatf("target_count got %0d want %0d",
					got.target_count, want.target_count));
			if (got.overflow !== want.overflow)
				report_mismatch($sformatf("overflow got %0d want %0d",
					got.overflow, want.overflow));
			if (got.last !== want.last)
				report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [31:0]          receding_magnitude;
	logic [31:0]          approaching_magnitude;
	logic                 last_bin;
	logic                 out_valid;
	logic                 out_stall;
	logic                 kind;
	logic                 direction;
	logic [9:0]           bin_index;
	logic [31:0]          speed_kph;
	logic [4:0]           target_count;
	logic                 overflow;
	logic                 last;

	target_scoreboard sb = new();
	bit               quiet;
	bit               long_hold_req;
	int               items_sent;

	doppler_peak_target_detector_core u_top (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.receding_magnitude    (receding_magnitude),
		.approaching_magnitude (approaching_magnitude),
		.last_bin              (last_bin),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.kind                  (kind),
		.direction             (direction),
		.bin_index             (bin_index),
		.speed_kph             (speed_kph),
		.target_count          (target_count),
		.overflow              (overflow),
		.last                  (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
		logic [31:0] mid);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return mid;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({kind, direction, bin_index, speed_kph, target_count, overflow, last});
	end

	initial begin
		int run_left;
		int stall_left;
		int hold_left;
		run_left   = 0;
		stall_left = 0;
		hold_left  = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
						: $urandom_range(0, 8);
					stall_left = gap_len();
				end
			end
		end
	end

	task automatic send_bin(logic [31:0] rec, logic [31:0] app, logic mark, bit no_gap);
		int gap;
		in_valid              <= 1'b1;
		receding_magnitude    <= rec;
		approaching_magnitude <= app;
		last_bin              <= mark;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_bin(rec, app, mark);
		items_sent++;
		gap = (no_gap || quiet) ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(int len, frame_style_e style, int shift, bit marked, bit no_gap);
		logic [31:0] rec;
		logic [31:0] app;
		logic        mark;
		for (int i = 0; i < len; i++) begin
			if (style == FR_ZIGZAG) begin
				rec = (i % 2) ? $urandom_range(1000, 32'hFFFF_FFFF) : $urandom_range(0, 999);
				app = (i % 2) ? $urandom_range(1000, 32'hFFFF_FFFF) : $urandom_range(0, 999);
			end else begin
				rec = $urandom >> shift;
				app = $urandom >> shift;
			end
			mark = marked && (i == len - 1);
			if (style == FR_NOISE && $urandom_range(0, 7) == 0)
				mark = 1'b1;
			send_bin(rec, app, mark, no_gap);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic end_phase();
		in_valid <= 1'b0;
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int start;
		int wait_cycles;
		arst_n                <= 1'b0;
		cfg_valid             <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		in_valid              <= 1'b0;
		receding_magnitude    <= '0;
		approaching_magnitude <= '0;
		last_bin              <= 1'b0;
		quiet                  = 1'b0;
		long_hold_req          = 1'b0;
		items_sent             = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: peaks on both sides, a candidate on the closing bin,
		// a one-bin frame and a flat top that must not count as a peak.
		send_bin(32'd5, 32'd5, 1'b0, 1'b0);
		send_bin(32'd10, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_bin(32'd3, 32'd1, 1'b0, 1'b0);
		send_bin(32'd0, 32'd0, 1'b1, 1'b0);
		send_bin(32'd1, 32'd1, 1'b0, 1'b0);
		send_bin(32'd2, 32'd2, 1'b0, 1'b0);
		send_bin(32'd9, 32'd9, 1'b1, 1'b0);
		send_bin(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
		send_bin(32'd1, 32'd1, 1'b0, 1'b0);
		send_bin(32'd7, 32'd7, 1'b0, 1'b0);
		send_bin(32'd7, 32'd7, 1'b0, 1'b0);
		send_bin(32'd2, 32'd2, 1'b1, 1'b0);
		end_phase();

		// A value equal to the threshold is not above it; the zigzag frame
		// overflows the target list and saturates the speed.
		write_reg(REG_THRESHOLD, 32'd7);
		write_reg(REG_LOW_BIN, 32'd0);
		write_reg(REG_HIGH_BIN, 32'd1024);
		write_reg(REG_SKIP_BINS, 32'd0);
		write_reg(REG_SPEED_PER_BIN, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_bin(32'd0, 32'd0, 1'b0, 1'b0);
		send_bin(32'd7, 32'd8, 1'b0, 1'b0);
		send_bin(32'd0, 32'd0, 1'b1, 1'b0);
		send_frame(24, FR_ZIGZAG, 0, 1'b1, 1'b0);
		end_phase();

		write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_frame(12, FR_SCALED, 0, 1'b1, 1'b0);
		send_frame(6, FR_ZIGZAG, 0, 1'b1, 1'b0);
		end_phase();

		write_reg(REG_THRESHOLD, 32'd0);
		write_reg(REG_LOW_BIN, 32'd1024);
		write_reg(REG_HIGH_BIN, 32'd0);
		cfg_valid <= 1'b0;
		send_frame(10, FR_ZIGZAG, 0, 1'b1, 1'b0);
		end_phase();

		write_reg(REG_LOW_BIN, 32'd1);
		write_reg(REG_HIGH_BIN, 32'd1024);
		write_reg(REG_SKIP_BINS, 32'd1023);
		write_reg(REG_SPEED_PER_BIN, 32'd0);
		cfg_valid <= 1'b0;
		send_frame(20, FR_ZIGZAG, 0, 1'b1, 1'b0);
		end_phase();

		// Small magnitudes with a short skip after each target.
		write_reg(REG_SKIP_BINS, 32'd3);
		write_reg(REG_SPEED_PER_BIN, 32'd65536);
		cfg_valid <= 1'b0;
		send_frame(40, FR_SCALED, 24, 1'b1, 1'b0);
		end_phase();

		// Output held off while bins keep coming, so the queue fills.
		write_reg(REG_SKIP_BINS, 32'd0);
		cfg_valid <= 1'b0;
		long_hold_req = 1'b1;
		send_frame(30, FR_ZIGZAG, 0, 1'b1, 1'b1);
		end_phase();

		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 1))
				write_reg(REG_THRESHOLD,
					pick_value(32'd0, 32'hFFFF_FFFF, $urandom >> $urandom_range(8, 31)));
			if ($urandom_range(0, 1))
				write_reg(REG_LOW_BIN, pick_value(32'd0, 32'd1024, $urandom_range(0, 12)));
			if ($urandom_range(0, 1))
				write_reg(REG_HIGH_BIN, pick_value(32'd0, 32'd1024, $urandom_range(0, 48)));
			if ($urandom_range(0, 1))
				write_reg(REG_SKIP_BINS, pick_value(32'd0, 32'd1023, $urandom_range(0, 5)));
			if ($urandom_range(0, 1))
				write_reg(REG_SPEED_PER_BIN, pick_value(32'd0, 32'hFFFF_FFFF, $urandom));
			cfg_valid <= 1'b0;
			repeat ($urandom_range(2, 5)) begin
				quiet = ($urandom_range(0, 4) == 0);
				case ($urandom_range(0, 3))
					0, 1: send_frame($urandom_range(1, 40), FR_SCALED,
						($urandom_range(0, 3) == 0) ? 0 : $urandom_range(20, 31), 1'b1, 1'b0);
					2: send_frame($urandom_range(2, 40), FR_ZIGZAG, 0, 1'b1, 1'b0);
					default: send_frame($urandom_range(2, 30), FR_NOISE, $urandom_range(0, 31),
						$urandom_range(0, 1), 1'b0);
				endcase
			end
			quiet = 1'b0;
			end_phase();
		end

		in_valid <= 1'b0;
		for (wait_cycles = 0; sb.pending_reports.size() != 0 && wait_cycles < DRAIN_LIMIT;
			wait_cycles++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_reports.size() != 0)
			sb.report_mismatch($sformatf("%0d expected results never arrived",
				sb.pending_reports.size()));
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
